>>> hw/rtl/sha256_pkg.sv
package sha256_pkg;

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic REQ_DATA   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef enum logic [1:0] {
    BSEL_DATA = 2'd0,
    BSEL_PAD  = 2'd1,
    BSEL_ZERO = 2'd2,
    BSEL_LEN  = 2'd3
  } bsel_t;

  typedef struct packed {
    logic       buf_we;
    bsel_t      buf_sel;
    logic [5:0] buf_addr;
    logic       cnt_add;
    logic       msg_init;
    logic       load_w;
    logic       comp_start;
    logic       round_en;
    logic [5:0] round;
    logic       feed_fwd;
    logic [2:0] out_sel;
  } sha_cmd_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> hw/rtl/sha256_datapath.sv
module sha256_datapath (
  input  logic                  clk,
  input  logic [7:0]            data_byte,
  input  sha256_pkg::sha_cmd_t  cmd,
  output logic [31:0]           hash_word
);

  logic [7:0]  mem [64];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [63:0] bit_count_r;
  logic [7:0]  wr_byte;
  logic [7:0]  rd_byte_r;
  logic [31:0] s0, s1, w_new, t1, t2, e, a, wi;
  logic [2:0]  len_idx;

  assign len_idx = cmd.buf_addr[2:0];

  always_comb begin
    case (cmd.buf_sel)
      sha256_pkg::BSEL_DATA: wr_byte = data_byte;
      sha256_pkg::BSEL_PAD:  wr_byte = sha256_pkg::PAD_BYTE;
      sha256_pkg::BSEL_ZERO: wr_byte = 8'h00;
      sha256_pkg::BSEL_LEN:  wr_byte = bit_count_r[8'(7 - len_idx) * 8 +: 8];
      default:               wr_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.buf_we) begin
      mem[cmd.buf_addr] <= wr_byte;
    end
    rd_byte_r <= mem[cmd.buf_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.msg_init) begin
      bit_count_r <= '0;
    end else if (cmd.cnt_add) begin
      bit_count_r <= bit_count_r + 64'd8;
    end
  end

  // schedule window: w_r[0] is w[i]
  assign s0 = sha256_pkg::rotr(w_r[1], 7) ^ sha256_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1 = sha256_pkg::rotr(w_r[14], 17) ^ sha256_pkg::rotr(w_r[14], 19)
            ^ (w_r[14] >> 10);
  assign w_new = s1 + w_r[9] + s0 + w_r[0];
  assign wi = w_r[0];

  assign e  = v_r[4];
  assign a  = v_r[0];
  assign t1 = v_r[7] + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11)
            ^ sha256_pkg::rotr(e, 25)) + ((e & v_r[5]) ^ (~e & v_r[6]))
            + sha256_pkg::RK[cmd.round] + wi;
  assign t2 = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22))
            + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_ff @(posedge clk) begin
    if (cmd.load_w) begin
      // byte-wide shift through the whole block
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= {w_r[i][23:0], w_r[i+1][31:24]};
      end
      w_r[15] <= {w_r[15][23:0], rd_byte_r};
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      v_r <= h_r;
    end else if (cmd.round_en) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.msg_init) begin
      h_r <= sha256_pkg::IV;
    end else if (cmd.feed_fwd) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

  assign hash_word = h_r[cmd.out_sel];

endmodule

>>> hw/rtl/sha256_ctrl.sv
module sha256_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_word_index,
  output logic                  out_last_word,
  output sha256_pkg::sha_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_FF   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [5:0] fill_r, fill_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic       fin_r, fin_nxt;
  logic       len_r, len_nxt;
  logic       accept;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT);
  assign out_word_index = cnt_r[2:0];
  assign out_last_word  = (cnt_r[2:0] == 3'd7);

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    len_nxt   = len_r;
    cmd       = '0;
    cmd.buf_addr = fill_r;
    cmd.buf_sel  = sha256_pkg::BSEL_DATA;
    cmd.out_sel  = cnt_r[2:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.buf_we = 1'b1;
          fill_nxt = fill_r + 6'd1;
          if (in_req_type == sha256_pkg::REQ_DATA) begin
            cmd.cnt_add = 1'b1;
            if (fill_r == 6'd63) begin
              fin_nxt = 1'b0;
              cnt_nxt = '0;
              state_nxt = S_LOAD;
            end
          end else begin
            cmd.buf_sel = sha256_pkg::BSEL_PAD;
            fin_nxt = 1'b1;
            // length fits behind the pad byte in this block
            len_nxt = (fill_r < sha256_pkg::LEN_POS);
            cnt_nxt = '0;
            state_nxt = (fill_r == 6'd63) ? S_LOAD : S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.buf_we = 1'b1;
        if (len_r && fill_r >= sha256_pkg::LEN_POS) begin
          cmd.buf_sel = sha256_pkg::BSEL_LEN;
        end else begin
          cmd.buf_sel = sha256_pkg::BSEL_ZERO;
        end
        fill_nxt = fill_r + 6'd1;
        if (fill_r == 6'd63) begin
          cnt_nxt = '0;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.buf_addr = cnt_r[5:0];
        cmd.load_w = (cnt_r != 7'd0);
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd64) begin
          cmd.comp_start = 1'b1;
          cnt_nxt = '0;
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        cmd.round_en = 1'b1;
        cmd.round = cnt_r[5:0];
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          cnt_nxt = '0;
          state_nxt = S_FF;
        end
      end
      S_FF: begin
        cmd.feed_fwd = 1'b1;
        fill_nxt = '0;
        cnt_nxt = '0;
        if (!fin_r) begin
          state_nxt = S_IDLE;
        end else if (len_r) begin
          state_nxt = S_OUT;
        end else begin
          // extra block of zeros and the length
          len_nxt = 1'b1;
          state_nxt = S_PAD;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_r[2:0] == 3'd7) begin
            cmd.msg_init = 1'b1;
            cnt_nxt = '0;
            fill_nxt = '0;
            fin_nxt = 1'b0;
            len_nxt = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= '0;
      cnt_r <= '0;
      fin_r <= 1'b0;
      len_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      cnt_r <= cnt_nxt;
      fin_r <= fin_nxt;
      len_r <= len_nxt;
    end
  end

endmodule

>>> hw/rtl/sha256_stream_hasher.sv
// SHA-256 over a byte stream: one data word carries one message byte. A word that
// completes a 64-byte block starts its load into the message schedule, its compression
// and its feed-forward, during which in_stall is high.
// A finish word pads the rest of the block at one byte per cycle, compresses it and,
// when the length no longer fits, pads and compresses a second block. It then presents
// the eight digest words in order, one per cycle unless out_stall holds them, the last
// one flagged; the hash then restarts for a new message.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha256_pkg::sha_cmd_t cmd;

  sha256_pkg::sha_cmd_t cmd_dp;

  always_comb begin
    cmd_dp = cmd;
    if (!rst_n) begin
      cmd_dp.msg_init = 1'b1;
    end
  end

  sha256_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word),
    .cmd            (cmd)
  );

  sha256_datapath u_dp (
    .clk       (clk),
    .data_byte (in_data_byte),
    .cmd       (cmd_dp),
    .hash_word (out_digest_word)
  );

endmodule
